>>> hdl/pva_pkg.sv
package pva_pkg;

   localparam int unsigned NOTE_W = 7;
   localparam int unsigned VEL_W  = 7;
   localparam int unsigned AGE_W  = 32;
   localparam int unsigned SR_W   = 24;
   localparam int unsigned FREQ_W = 24;
   localparam int unsigned LVL_W  = 16;

   localparam logic [1:0] OP_NOTE_ON      = 2'd0;
   localparam logic [1:0] OP_NOTE_RELEASE = 2'd1;
   localparam logic [1:0] OP_TICK         = 2'd2;

   localparam logic [1:0] CSR_RELEASE_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_RELEASE_RECIP   = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_PERIOD   = 2'd2;

   localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd89478;

   typedef struct packed {
      logic [1:0]        op;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  velocity;
   } cmd_type;

   typedef struct packed {
      logic [LVL_W-1:0] decay;
      logic [LVL_W-1:0] level;
      logic [31:0]      runtime;
      logic [FREQ_W-1:0] frequency;
      logic [NOTE_W-1:0] voice_note;
      logic             voice_valid;
      logic             is_released;
      logic             dropped;
      logic             last;
   } rsp_type;

   // Octave-4 pitch table, notes 60..71, Q.20 hertz.
   function automatic logic [31:0] octave4_q20(input logic [3:0] idx);
      logic [31:0] v;
      case (idx)
         4'd0:  v = 32'd274334289;
         4'd1:  v = 32'd290647055;
         4'd2:  v = 32'd307929828;
         4'd3:  v = 32'd326240288;
         4'd4:  v = 32'd345639545;
         4'd5:  v = 32'd366192342;
         4'd6:  v = 32'd387967272;
         4'd7:  v = 32'd411037006;
         4'd8:  v = 32'd435478539;
         4'd9:  v = 32'd461373440;
         4'd10: v = 32'd488808132;
         4'd11: v = 32'd517874177;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Equal-tempered frequency of a note, Q14.10, rounded half up.
   function automatic logic [FREQ_W-1:0] note_frequency(input logic [NOTE_W-1:0] n);
      logic [12:0] q;
      logic [3:0]  oct;
      logic [3:0]  pc;
      logic [3:0]  sh;
      logic [32:0] sum;
      // The octave is n / 12, taken as (n * 43) >> 9, which is exact for every note.
      q   = 13'(n) * 13'd43;
      oct = q[12:9];
      pc  = 4'(n - 7'(oct) * 7'd12);
      sh  = 4'd15 - oct;
      sum = {1'b0, octave4_q20(pc)} + (33'd1 << (sh - 4'd1));
      return FREQ_W'(sum >> sh);
   endfunction

   // round(v * 32768 / 127); the division by 127 is a multiplication by
   // ceil(2^29 / 127) and a shift, exact over the whole velocity range.
   function automatic logic [LVL_W-1:0] vel_level(input logic [VEL_W-1:0] v);
      logic [22:0] p;
      logic [45:0] prod;
      p    = ({16'd0, v} << 15) + 23'd63;
      prod = {23'd0, p} * 46'd4227331;
      return LVL_W'(prod >> 29);
   endfunction

endpackage

>>> hdl/pva_front.sv
module pva_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,
   input  logic [15:0]      req_tdata,
   output logic             q_valid,
   input  logic             q_ready,
   output pva_pkg::cmd_type q_cmd
);
   import pva_pkg::*;

   // Two-entry queue; unknown ops are dropped here and never reach the back end.
   cmd_type   mem_ff [2];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;
   cmd_type   cmd;

   always_comb begin
      cmd.op       = req_tuser;
      cmd.note     = req_tdata[NOTE_W-1:0];
      cmd.velocity = req_tdata[8 +: VEL_W];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push  = req_tvalid && req_tready && (req_tuser != 2'd3);
   assign pop   = q_valid && q_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= cmd;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");

endmodule

>>> hdl/pva_back.sv
module pva_back #(
   parameter int unsigned MAX_VOICES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  pva_pkg::cmd_type q_cmd,
   input  logic [23:0]      release_samples,
   input  logic [31:0]      release_recip,
   input  logic [31:0]      sample_period,
   output logic             o_valid,
   input  logic             o_ready,
   output pva_pkg::rsp_type o_rsp
);
   import pva_pkg::*;

   localparam int unsigned IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int unsigned CW = $clog2(MAX_VOICES + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOOK = 6'b000010,
      ST_REL  = 6'b000100,
      ST_WALK = 6'b001000,
      ST_CALC = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   // Voice table: per-entry registers, each walked by index.
   logic [NOTE_W-1:0] vnote_ff [MAX_VOICES];
   logic [VEL_W-1:0]  vvel_ff  [MAX_VOICES];
   logic              vrel_ff  [MAX_VOICES];
   logic              vdead_ff [MAX_VOICES];
   logic [AGE_W-1:0]  vage_ff  [MAX_VOICES];
   logic [SR_W-1:0]   vsr_ff   [MAX_VOICES];
   logic [IW-1:0]     newest_ff [128];
   logic [127:0]      nvalid_ff;
   logic [CW-1:0]     count_ff;
   logic              drop_ff;
   cmd_type           cmd_ff;
   logic [IW-1:0]     tgt_ff;
   logic              tgt_ok_ff;
   logic [CW-1:0]     rd_ff, wr_ff;
   logic              any_ff;
   // Result computation stage.
   logic [63:0]       rt_prod_ff;
   logic [55:0]       dc_prod_ff;
   logic              dc_zero_ff, c_rel_ff;
   logic [NOTE_W-1:0] c_note_ff;
   logic [VEL_W-1:0]  c_vel_ff;
   logic              c_last_ff;
   rsp_type           res_ff;
   rsp_type           out_ff;
   logic              ov_ff;

   logic [IW-1:0] rdi, wri;
   logic          kill, full, last_live;
   logic [CW-1:0] nxt;
   logic [SR_W-1:0] sr_r;

   assign rdi  = rd_ff[IW-1:0];
   assign wri  = wr_ff[IW-1:0];
   assign full = (count_ff >= CW'(MAX_VOICES));
   assign sr_r = vsr_ff[rdi];
   assign kill = vdead_ff[rdi] || (vrel_ff[rdi] && (sr_r > release_samples));
   assign nxt  = rd_ff + CW'(1);

   // Is any live voice still ahead of the read pointer? Scanned with a small loop of
   // independent compares.
   always_comb begin
      last_live = 1'b1;
      for (int j = 0; j < MAX_VOICES; j++) begin
         if (CW'(j) > rd_ff && CW'(j) < count_ff &&
             !(vdead_ff[j] || (vrel_ff[j] && vsr_ff[j] > release_samples))) begin
            last_live = 1'b0;
         end
      end
   end

   assign q_ready = (state_ff == ST_IDLE);
   assign o_valid = ov_ff;
   assign o_rsp   = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_cmd.op == OP_TICK) ? ST_WALK : ST_LOOK;
            end
         end
         ST_LOOK: state_in = ST_REL;
         ST_REL:  state_in = ST_IDLE;
         ST_WALK: begin
            if (rd_ff >= count_ff) begin
               state_in = any_ff ? ST_IDLE : ST_CALC;
            end else if (!kill) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!ov_ff || o_ready) begin
               state_in = (!any_ff || c_last_ff) ? ST_IDLE : ST_WALK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff <= q_cmd;
            rd_ff  <= '0;
            wr_ff  <= '0;
         end
         ST_LOOK: begin
            tgt_ff    <= newest_ff[cmd_ff.note];
            tgt_ok_ff <= nvalid_ff[cmd_ff.note];
         end
         ST_REL: begin
            if (!(cmd_ff.op == OP_NOTE_ON && full)) begin
               if (tgt_ok_ff && CW'(tgt_ff) < count_ff) begin
                  vrel_ff[tgt_ff] <= 1'b1;
                  if (release_samples == '0) begin
                     vdead_ff[tgt_ff] <= 1'b1;
                  end
               end
               if (cmd_ff.op == OP_NOTE_ON) begin
                  vnote_ff[count_ff[IW-1:0]] <= cmd_ff.note;
                  vvel_ff[count_ff[IW-1:0]]  <= cmd_ff.velocity;
                  vrel_ff[count_ff[IW-1:0]]  <= 1'b0;
                  vdead_ff[count_ff[IW-1:0]] <= 1'b0;
                  vage_ff[count_ff[IW-1:0]]  <= '0;
                  vsr_ff[count_ff[IW-1:0]]   <= '0;
                  newest_ff[cmd_ff.note]     <= count_ff[IW-1:0];
               end
            end
         end
         ST_WALK: begin
            if (rd_ff < count_ff) begin
               c_last_ff  <= last_live;
               c_note_ff  <= vnote_ff[rdi];
               c_vel_ff   <= vvel_ff[rdi];
               c_rel_ff   <= vrel_ff[rdi];
               dc_zero_ff <= (sr_r >= release_samples);
               rt_prod_ff <= {32'd0, vage_ff[rdi]} * {32'd0, sample_period};
               dc_prod_ff <= {32'd0, release_samples - sr_r} * {24'd0, release_recip};
               rd_ff      <= nxt;
               if (!kill) begin
                  // Compact forward, advancing the counters of the kept voice.
                  vnote_ff[wri] <= vnote_ff[rdi];
                  vvel_ff[wri]  <= vvel_ff[rdi];
                  vrel_ff[wri]  <= vrel_ff[rdi];
                  vdead_ff[wri] <= 1'b0;
                  vage_ff[wri]  <= (vage_ff[rdi] == '1) ? vage_ff[rdi]
                                                         : vage_ff[rdi] + AGE_W'(1);
                  vsr_ff[wri]   <= (vrel_ff[rdi] && sr_r != '1) ? sr_r + SR_W'(1) : sr_r;
                  newest_ff[vnote_ff[rdi]] <= wri;
                  wr_ff <= wr_ff + CW'(1);
               end
            end
         end
         ST_CALC: begin
            res_ff.voice_valid <= any_ff;
            res_ff.voice_note  <= any_ff ? c_note_ff : '0;
            res_ff.frequency   <= any_ff ? note_frequency(c_note_ff) : '0;
            res_ff.level       <= any_ff ? vel_level(c_vel_ff) : '0;
            res_ff.runtime     <= !any_ff ? '0 :
                                  (rt_prod_ff[63:48] != '0) ? '1 : rt_prod_ff[47:16];
            res_ff.decay       <= !any_ff ? '0 : !c_rel_ff ? 16'd32768 :
                                  dc_zero_ff ? '0 :
                                  (dc_prod_ff[55:17] > 39'd32768) ? 16'd32768 :
                                  dc_prod_ff[32:17];
            res_ff.is_released <= any_ff && c_rel_ff;
            res_ff.dropped     <= drop_ff;
            res_ff.last        <= !any_ff || c_last_ff;
         end
         ST_EMIT: begin
            // The output register takes the new result once the previous one is gone.
            if (!ov_ff || o_ready) begin
               out_ff <= res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         nvalid_ff <= '0;
         ov_ff     <= 1'b0;
         any_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EMIT && (!ov_ff || o_ready)) begin
            ov_ff <= 1'b1;
         end else if (o_valid && o_ready) begin
            ov_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid && q_cmd.op == OP_TICK) begin
                  nvalid_ff <= '0;
                  any_ff    <= 1'b0;
               end
            end
            ST_REL: begin
               if (cmd_ff.op == OP_NOTE_ON) begin
                  if (full) begin
                     drop_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                     nvalid_ff[cmd_ff.note] <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               if (rd_ff < count_ff && !kill) begin
                  nvalid_ff[vnote_ff[rdi]] <= 1'b1;
                  any_ff <= 1'b1;
                  // Past the last live voice only expired entries remain.
                  if (last_live) begin
                     count_ff <= wr_ff + CW'(1);
                  end
               end
               if (rd_ff >= count_ff) begin
                  count_ff <= wr_ff;
               end
            end
            ST_EMIT: begin
               if ((!ov_ff || o_ready) && (!any_ff || c_last_ff)) begin
                  drop_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VOICES)) else $error("voice count beyond table");
   a_compact: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> wr_ff <= rd_ff) else $error("compaction overtook read");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REL && cmd_ff.op == OP_NOTE_ON && full |=> drop_ff)
      else $error("drop flag not set on full table");

endmodule

>>> hdl/poly_voice_allocator_unit.sv
// Polyphonic voice allocator. MIDI note-on, note-release and tick transfers come in on req_;
// each tick returns one rsp_ transfer per live voice, oldest first, or one empty
// transfer when no voice is live, with rsp_tlast on the final one. A front queue of two
// entries takes transfers while the back end works. A note event passes accept, lookup of
// the note's newest voice, then release and append. A tick starts a walk that compacts the
// table, taking each live voice through walk, calc and emit and each expired voice ahead
// of the last live one through walk only; an empty table gives its single result through
// walk, calc and emit. Each result waits in an output register, and the back end stalls
// only when the next result is ready before the receiver has taken the waiting one.
// Configuration is to be written only while idle; the block itself does not enforce it.
module poly_voice_allocator_unit #(
   parameter int unsigned MAX_VOICES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: note[6:0], velocity[14:8], zero pad [15].
   input  logic [15:0] req_tdata,
   // tuser: op[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: voice_note[6:0], frequency[30:7], level[46:31], runtime[78:47],
   // decay[94:79], zero pad [95].
   output logic [95:0] rsp_tdata,
   // tuser: voice_valid[0], is_released[1], dropped[2].
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pva_pkg::*;

   logic [23:0] release_samples_ff;
   logic [31:0] release_recip_ff, sample_period_ff;
   logic        q_valid, q_ready;
   cmd_type     q_cmd;
   rsp_type     rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_samples_ff <= '0;
         release_recip_ff   <= '0;
         sample_period_ff   <= SAMPLE_PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RELEASE_SAMPLES: release_samples_ff <= csr_data[23:0];
            CSR_RELEASE_RECIP:   release_recip_ff   <= csr_data;
            CSR_SAMPLE_PERIOD:   sample_period_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   pva_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .q_valid, .q_ready, .q_cmd
   );

   pva_back #(.MAX_VOICES(MAX_VOICES)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd,
      .release_samples(release_samples_ff),
      .release_recip(release_recip_ff),
      .sample_period(sample_period_ff),
      .o_valid(rsp_tvalid), .o_ready(rsp_tready), .o_rsp(rsp)
   );

   assign rsp_tdata = {1'b0, rsp.decay, rsp.runtime, rsp.level, rsp.frequency,
                       rsp.voice_note};
   assign rsp_tuser = {rsp.dropped, rsp.is_released, rsp.voice_valid};
   assign rsp_tlast = rsp.last;

endmodule
